[src/kct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_pkg
// shared types and constants of the keyed reference count table
// ----------------------------------------------------------------------------
package kct_pkg;

    localparam int DEF_SLOTS  = 16;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] COUNT_ONE = CNT_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED = 3'd0,
        ST_NEW     = 3'd1,
        ST_FREED   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic                  vld;
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [CNT_W-1:0]      count;
    } t_result;

endpackage

[src/keyed_reference_count_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_reference_count_table
// get / put reference counting over a table of keyed slots
//
//   channel   handshake              payload
//   request   start, busy            i_func, i_object_key
//   result    o_strobe (one cycle)   o_status, o_slot_index, o_count_after
//
// a request with a nonzero key raises the result strobe after a sequential walk of
// the slot store, one read a cycle, through the scan, drain and done states and the
// result register; a null key request skips to the done state and result register
// busy is high from acceptance until the cycle the result is written back
// synchronous reset clears the slot valid bits at once; the receiver never stalls
// ----------------------------------------------------------------------------
module keyed_reference_count_table #(
    parameter int SLOTS = kct_pkg::DEF_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [kct_pkg::KEY_W-1:0]     i_object_key,
    output logic                          o_strobe,
    output logic [kct_pkg::STATUS_W-1:0]  o_status,
    output logic [kct_pkg::SLOT_OUT_W-1:0] o_slot_index,
    output logic [kct_pkg::CNT_W-1:0]     o_count_after
);
    import kct_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    t_entry        rd_data;
    t_result       result;
    logic          r_strobe;
    t_result       r_result;

    kct_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    kct_scan #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_object_key (i_object_key),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= result.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.vld) begin
            r_result <= result;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_result.status;
    assign o_slot_index  = r_result.slot;
    assign o_count_after = r_result.count;

endmodule

[src/kct_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_mem
// slot store: key and count per slot, one write and one registered read port
// ----------------------------------------------------------------------------
module kct_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  kct_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [IW-1:0]   i_rd_addr,
    output kct_pkg::t_entry o_rd_data
);
    import kct_pkg::*;

    t_entry mem [SLOTS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/kct_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_scan
// request sequencer: walks the slot store, tracks hit and lowest free slot,
// keeps the valid bits and writes the updated entry back
// ----------------------------------------------------------------------------
module kct_scan #(
    parameter int SLOTS = 16,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [kct_pkg::KEY_W-1:0]  i_object_key,
    output logic                       o_wr_en,
    output logic [IW-1:0]              o_wr_addr,
    output kct_pkg::t_entry            o_wr_data,
    output logic                       o_rd_en,
    output logic [IW-1:0]              o_rd_addr,
    input  kct_pkg::t_entry            i_rd_data,
    output kct_pkg::t_result           o_result
);
    import kct_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_pend;
    logic [IW-1:0]    r_pend_idx;
    logic             r_func;
    logic [KEY_W-1:0] r_key;
    logic             r_null, n_null;
    logic             r_found, n_found;
    logic [IW-1:0]    r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic             r_have_free, n_have_free;
    logic [IW-1:0]    r_free_idx, n_free_idx;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic             pend_valid;

    assign pend_valid = r_valid[r_pend_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_idx  <= r_idx;
        r_null      <= n_null;
        r_found     <= n_found;
        r_hit_idx   <= n_hit_idx;
        r_hit_cnt   <= n_hit_cnt;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        if (r_state == S_IDLE && start) begin
            r_func <= i_func;
            r_key  <= i_object_key;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_null      = r_null;
        n_found     = r_found;
        n_hit_idx   = r_hit_idx;
        n_hit_cnt   = r_hit_cnt;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_valid     = r_valid;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_hit_idx;
        o_wr_data   = '{key: r_key, count: COUNT_ONE};
        o_result    = '{vld: 1'b0, status: ST_NULL, slot: '0, count: '0};

        // compare the entry read in the previous cycle
        if (r_pend) begin
            if (pend_valid && i_rd_data.key == r_key && !r_found) begin
                n_found   = 1'b1;
                n_hit_idx = r_pend_idx;
                n_hit_cnt = i_rd_data.count;
            end
            if (!pend_valid && !r_have_free) begin
                n_have_free = 1'b1;
                n_free_idx  = r_pend_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_null      = (i_object_key == '0);
                    n_state     = (i_object_key == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_rd_en = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state      = S_IDLE;
                o_result.vld = 1'b1;
                if (r_null) begin
                    o_result.status = ST_NULL;
                end else if (!r_found) begin
                    if (r_have_free) begin
                        o_wr_en             = 1'b1;
                        o_wr_addr           = r_free_idx;
                        n_valid[r_free_idx] = 1'b1;
                        o_result.status     = ST_NEW;
                        o_result.slot       = SLOT_OUT_W'(r_free_idx);
                        o_result.count      = COUNT_ONE;
                    end else begin
                        o_result.status = ST_FULL;
                    end
                end else if (r_func) begin
                    o_wr_en             = 1'b1;
                    o_wr_data.count     = (r_hit_cnt == COUNT_MAX) ? COUNT_MAX
                                                                   : r_hit_cnt + COUNT_ONE;
                    o_result.status     = ST_UPDATED;
                    o_result.slot       = SLOT_OUT_W'(r_hit_idx);
                    o_result.count      = o_wr_data.count;
                end else if (r_hit_cnt <= COUNT_ONE) begin
                    n_valid[r_hit_idx] = 1'b0;
                    o_result.status    = ST_FREED;
                    o_result.slot      = SLOT_OUT_W'(r_hit_idx);
                end else begin
                    o_wr_en         = 1'b1;
                    o_wr_data.count = r_hit_cnt - COUNT_ONE;
                    o_result.status = ST_UPDATED;
                    o_result.slot   = SLOT_OUT_W'(r_hit_idx);
                    o_result.count  = o_wr_data.count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule
